// ===== hw/rtl/xfc_pkg.sv =====
package xfc_pkg;

   localparam int MAX_FRAME = 64;
   localparam int COUNT_W = $clog2(MAX_FRAME + 1);
   localparam int MIN_FRAME = 10;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int REPLY_LEN = 12;
   localparam int REPLY_IDX_W = $clog2(REPLY_LEN);

   localparam logic [7:0] HEAD_0 = 8'h59;
   localparam logic [7:0] HEAD_1 = 8'h58;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] REPLY_CMD = 8'hBB;
   localparam logic [7:0] REPLY_LEN_BYTE = 8'h02;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_RX_FAIL = 2'd1;
   localparam logic [1:0] STATUS_FORMAT = 2'd2;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_frame;
      logic       timeout_event;
   } xfc_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] echo_command;
      logic [7:0] reply_byte;
      logic       reply_valid;
      logic       last_result;
   } xfc_rsp_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] echo;
   } xfc_verdict_type;

   localparam logic [REPLY_IDX_W-1:0] REPLY_LAST = REPLY_IDX_W'(REPLY_LEN - 1);

   function automatic logic [7:0] reply_byte_at(input logic [REPLY_IDX_W-1:0] idx,
                                                input logic [1:0] status,
                                                input logic [7:0] echo);
      logic [7:0] sum;
      logic [7:0] result;
      sum = HEAD_0 ^ HEAD_1 ^ REPLY_CMD ^ REPLY_LEN_BYTE ^ echo ^ {6'd0, status};
      unique case (idx)
         REPLY_IDX_W'(0):  result = HEAD_0;
         REPLY_IDX_W'(1):  result = HEAD_1;
         REPLY_IDX_W'(3):  result = REPLY_CMD;
         REPLY_IDX_W'(6):  result = REPLY_LEN_BYTE;
         REPLY_IDX_W'(7):  result = echo;
         REPLY_IDX_W'(8):  result = {6'd0, status};
         REPLY_IDX_W'(9):  result = sum;
         REPLY_IDX_W'(10): result = CHAR_CR;
         REPLY_IDX_W'(11): result = CHAR_LF;
         default:          result = 8'h00;
      endcase
      return result;
   endfunction

endpackage

// ===== hw/rtl/xfc_front.sv =====
module xfc_front
   import xfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  xfc_req_type     req_data,
   output logic            verdict_push,
   output xfc_verdict_type verdict
);

   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]         head_ff [4];
   logic [7:0]         head_in [4];
   logic [7:0]         tail_ff [3];
   logic [7:0]         tail_in [3];
   logic [7:0]         xor_ff, xor_in;
   logic [COUNT_W-1:0] cnt_nx;
   logic [7:0]         head_nx [4];
   logic [7:0]         tail_nx [3];
   logic [7:0]         xor_nx;
   logic               frame_end;

   // advance frame state by one byte
   always_comb begin
      cnt_nx  = cnt_ff;
      head_nx = head_ff;
      tail_nx = tail_ff;
      xor_nx  = xor_ff;
      if (cnt_ff < COUNT_W'(MAX_FRAME)) begin
         if (cnt_ff < COUNT_W'(4)) begin
            head_nx[cnt_ff[1:0]] = req_data.rx_byte;
         end
         xor_nx     = xor_ff ^ tail_ff[2];
         tail_nx[2] = tail_ff[1];
         tail_nx[1] = tail_ff[0];
         tail_nx[0] = req_data.rx_byte;
         cnt_nx     = cnt_ff + COUNT_W'(1);
      end
   end

   always_comb begin
      frame_end    = req_data.timeout_event || req_data.end_of_frame;
      verdict_push = accept && frame_end;
      verdict.echo = head_nx[3];
      priority if (req_data.timeout_event) begin
         verdict.status = STATUS_RX_FAIL;
         verdict.echo   = head_ff[2];
      end else if (cnt_nx < COUNT_W'(MIN_FRAME)) begin
         verdict.status = STATUS_RX_FAIL;
      end else if (head_nx[0] != HEAD_0 || head_nx[1] != HEAD_1) begin
         verdict.status = STATUS_FORMAT;
      end else if (tail_nx[1] != CHAR_CR || tail_nx[0] != CHAR_LF) begin
         verdict.status = STATUS_FORMAT;
      end else if (xor_nx != tail_nx[2]) begin
         verdict.status = STATUS_CHECKSUM;
      end else begin
         verdict.status = STATUS_OK;
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      xor_in  = xor_ff;
      if (accept) begin
         if (frame_end) begin
            cnt_in  = '0;
            head_in = '{default: 8'h00};
            tail_in = '{default: 8'h00};
            xor_in  = 8'h00;
         end else begin
            cnt_in  = cnt_nx;
            head_in = head_nx;
            tail_in = tail_nx;
            xor_in  = xor_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         head_ff <= '{default: 8'h00};
         tail_ff <= '{default: 8'h00};
         xor_ff  <= 8'h00;
      end else begin
         cnt_ff  <= cnt_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         xor_ff  <= xor_in;
      end
   end

endmodule

// ===== hw/rtl/xfc_queue.sv =====
module xfc_queue
   import xfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  xfc_verdict_type wr_data,
   output logic            q_full,
   input  logic            rd_en,
   output logic            q_empty,
   output xfc_verdict_type rd_data
);

   xfc_verdict_type        mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   do_wr;
   logic                   do_rd;

   assign q_full  = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign rd_data = mem[rd_ptr_ff];
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + QUEUE_CNT_W'(1);
      end else if (!do_wr && do_rd) begin
         cnt_in = cnt_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/xfc_back.sv =====
module xfc_back
   import xfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  xfc_verdict_type verdict,
   output logic            q_pop,
   output logic            empty,
   input  logic            pop,
   output xfc_rsp_type     rsp_data
);

   logic [REPLY_IDX_W-1:0] idx_ff, idx_in;
   logic                   out_valid_ff, out_valid_in;
   xfc_rsp_type            rsp_ff, rsp_in;
   logic                   load;
   logic                   is_ok;
   logic                   is_last;

   assign load    = (!out_valid_ff || pop) && !q_empty;
   assign is_ok   = (verdict.status == STATUS_OK);
   assign is_last = is_ok || (idx_ff == REPLY_LAST);
   assign q_pop   = load && is_last;
   assign empty   = !out_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      rsp_in       = rsp_ff;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in        = 1'b1;
         rsp_in.status       = verdict.status;
         rsp_in.echo_command = verdict.echo;
         rsp_in.reply_valid  = !is_ok;
         rsp_in.reply_byte   = is_ok ? 8'h00 : reply_byte_at(idx_ff, verdict.status, verdict.echo);
         rsp_in.last_result  = is_last;
         idx_in              = is_last ? '0 : idx_ff + REPLY_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

// ===== hw/rtl/xor_frame_checker_with_error_reply.sv =====
// Path: a frame's last byte (or a timeout), once accepted, writes its verdict into the
//   queue; the output register loads the first result word from there when it is free.
// Throughput: one input word per cycle while the four-entry verdict queue has room;
//   results: one word per popped cycle; one for a good frame, twelve for an error reply.
// Reset: synchronous, active high; clears frame state, the queue and the output stage.
module xor_frame_checker_with_error_reply
   import xfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  xfc_req_type req_data,
   output logic        empty,
   input  logic        pop,
   output xfc_rsp_type rsp_data
);

   logic            accept;
   logic            verdict_push;
   xfc_verdict_type verdict_wr;
   xfc_verdict_type verdict_rd;
   logic            q_full;
   logic            q_empty;
   logic            q_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   xfc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .verdict_push (verdict_push),
      .verdict      (verdict_wr)
   );

   xfc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (verdict_push),
      .wr_data (verdict_wr),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .q_empty (q_empty),
      .rd_data (verdict_rd)
   );

   xfc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .verdict  (verdict_rd),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hw/rtl/xfc_checker.sv =====
module xfc_checker
   import xfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  logic        pop,
   input  xfc_rsp_type rsp_data
);

   ok_word_is_single: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status == STATUS_OK) |->
         (!rsp_data.reply_valid && rsp_data.last_result))
      else $error("ok word must be a single word without reply data");

   error_word_is_reply: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status != STATUS_OK) |-> rsp_data.reply_valid)
      else $error("error status must carry a reply byte");

   reply_continues: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_data.reply_valid && !rsp_data.last_result) |=>
         (!empty && rsp_data.reply_valid && rsp_data.status == $past(rsp_data.status)))
      else $error("reply frame broken before its last byte");

   stalled_word_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result word changed or vanished");

   empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result side not empty after reset");

endmodule

bind xor_frame_checker_with_error_reply xfc_checker u_xfc_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

// ===== tb/xor_frame_checker_with_error_reply_tb.sv =====
module xor_frame_checker_with_error_reply_tb;
   import xfc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int WORD_TARGET = 460;

   typedef enum int {
      KIND_GOOD,
      KIND_BAD_HEAD,
      KIND_BAD_TAIL,
      KIND_BAD_SUM,
      KIND_CUT_SHORT,
      KIND_TIMED_OUT,
      KIND_NOISE
   } frame_kind_type;

   typedef struct {
      xfc_req_type req;
      bit          hold;
   } queued_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   xfc_req_type req_data = '0;
   logic        empty;
   logic        pop = 1'b0;
   xfc_rsp_type rsp_data;

   queued_word_type send_words[$];
   xfc_rsp_type     reply_words[$];
   queued_word_type next_word;

   logic [COUNT_W-1:0] frame_len;
   logic [7:0]         frame_head [0:3];
   logic [7:0]         frame_tail [0:2];
   logic [7:0]         frame_xor;

   int mismatches = 0;
   int words_sent = 0;
   int words_taken = 0;
   int stall_cycles = 0;
   int frame_no = 0;

   xor_frame_checker_with_error_reply dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task automatic clear_frame();
      frame_len = '0;
      for (int i = 0; i < 4; i++) frame_head[i] = 8'h00;
      for (int i = 0; i < 3; i++) frame_tail[i] = 8'h00;
      frame_xor = 8'h00;
   endtask

   task automatic queue_reply(input logic [1:0] code, input logic [7:0] echo);
      logic [7:0]  img [0:11];
      logic [7:0]  sum;
      xfc_rsp_type r;
      img = '{HEAD_0, HEAD_1, 8'h00, REPLY_CMD, 8'h00, 8'h00, REPLY_LEN_BYTE,
              echo, {6'd0, code}, 8'h00, CHAR_CR, CHAR_LF};
      sum = 8'h00;
      for (int i = 0; i < 9; i++) sum ^= img[i];
      img[9] = sum;
      for (int i = 0; i < REPLY_LEN; i++) begin
         r.status = code;
         r.echo_command = echo;
         r.reply_byte = img[i];
         r.reply_valid = 1'b1;
         r.last_result = (i == REPLY_LEN - 1);
         reply_words.push_back(r);
      end
   endtask

   task automatic track_frame(input xfc_req_type w);
      logic [1:0]  code;
      logic [7:0]  echo;
      xfc_rsp_type r;
      if (w.timeout_event) begin
         echo = frame_head[2];
         clear_frame();
         queue_reply(STATUS_RX_FAIL, echo);
      end else begin
         if (frame_len < MAX_FRAME) begin
            if (frame_len < 4) frame_head[frame_len[1:0]] = w.rx_byte;
            frame_xor ^= frame_tail[2];
            frame_tail[2] = frame_tail[1];
            frame_tail[1] = frame_tail[0];
            frame_tail[0] = w.rx_byte;
            frame_len++;
         end
         if (w.end_of_frame) begin
            echo = frame_head[3];
            if (frame_len < MIN_FRAME)
               code = STATUS_RX_FAIL;
            else if (frame_head[0] != HEAD_0 || frame_head[1] != HEAD_1)
               code = STATUS_FORMAT;
            else if (frame_tail[1] != CHAR_CR || frame_tail[0] != CHAR_LF)
               code = STATUS_FORMAT;
            else if (frame_xor != frame_tail[2])
               code = STATUS_CHECKSUM;
            else
               code = STATUS_OK;
            clear_frame();
            if (code != STATUS_OK) begin
               queue_reply(code, echo);
            end else begin
               r = '0;
               r.status = STATUS_OK;
               r.echo_command = echo;
               r.last_result = 1'b1;
               reply_words.push_back(r);
            end
         end
      end
   endtask

   task automatic add_word(input logic [7:0] b, input logic eof, input logic tmo,
                           input bit hold);
      queued_word_type p;
      p.req.rx_byte = b;
      p.req.end_of_frame = eof;
      p.req.timeout_event = tmo;
      p.hold = hold;
      send_words.push_back(p);
   endtask

   task automatic add_frame(input frame_kind_type kind, input int len, input bit hold);
      logic [7:0] bytes_buf [0:79];
      logic [7:0] sum;
      logic [7:0] flip;
      logic       eof;
      int         judged;
      int         cut;
      judged = (len < MAX_FRAME) ? len : MAX_FRAME;
      flip = 8'($urandom_range(255, 1));
      for (int i = 0; i < len; i++) bytes_buf[i] = 8'($urandom_range(255));
      if (kind != KIND_NOISE && judged >= MIN_FRAME) begin
         bytes_buf[0] = HEAD_0;
         bytes_buf[1] = HEAD_1;
         sum = 8'h00;
         for (int i = 0; i < judged - 3; i++) sum ^= bytes_buf[i];
         bytes_buf[judged - 3] = sum;
         bytes_buf[judged - 2] = CHAR_CR;
         bytes_buf[judged - 1] = CHAR_LF;
      end else if (kind == KIND_CUT_SHORT) begin
         bytes_buf[0] = HEAD_0;
         if (len > 1 && $urandom_range(1)) bytes_buf[1] = HEAD_1;
      end
      unique case (kind)
         KIND_BAD_HEAD: bytes_buf[$urandom_range(1)] ^= flip;
         KIND_BAD_TAIL: bytes_buf[judged - 2 + $urandom_range(1)] ^= flip;
         KIND_BAD_SUM:  bytes_buf[judged - 3] ^= flip;
         default: ;
      endcase
      cut = (kind == KIND_TIMED_OUT) ? $urandom_range(len - 1) : len;
      for (int i = 0; i < cut; i++) begin
         if (kind == KIND_TIMED_OUT)
            eof = 1'b0;
         else if (kind == KIND_NOISE)
            eof = ($urandom_range(7) == 0) || (i == len - 1);
         else
            eof = (i == len - 1);
         add_word(bytes_buf[i], eof, 1'b0, hold && i == 0);
      end
      if (kind == KIND_TIMED_OUT)
         add_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, hold && cut == 0);
   endtask

   task automatic add_random_frame();
      int  pick;
      int  len;
      bit  hold;
      frame_kind_type kind;
      pick = $urandom_range(99);
      hold = (frame_no % 15 == 14);
      frame_no++;
      if (pick < 55)      kind = KIND_GOOD;
      else if (pick < 65) kind = KIND_BAD_SUM;
      else if (pick < 73) kind = KIND_BAD_HEAD;
      else if (pick < 81) kind = KIND_BAD_TAIL;
      else if (pick < 87) kind = KIND_CUT_SHORT;
      else if (pick < 93) kind = KIND_TIMED_OUT;
      else                kind = KIND_NOISE;
      unique case (kind)
         KIND_CUT_SHORT: len = $urandom_range(9, 1);
         KIND_TIMED_OUT: len = $urandom_range(16, 1);
         KIND_NOISE:     len = $urandom_range(12, 1);
         default:        len = ($urandom_range(99) < 4) ? $urandom_range(72, 65)
                                                        : $urandom_range(20, 10);
      endcase
      add_frame(kind, len, hold);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            track_frame(req_data);
            words_sent++;
         end
         if (push && full) begin
            // hold the word until the block takes it
         end else if (send_words.size() != 0
                      && !(send_words[0].hold && reply_words.size() != 0)
                      && ((words_sent >= 150 && words_sent < 260)
                          || $urandom_range(99) >= 7)) begin
            next_word = send_words.pop_front();
            req_data <= next_word.req;
            push <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (reply_words.size() == 0) begin
               report_mismatch("result word with none pending");
            end else begin
               check_field("status", int'(rsp_data.status),
                           int'(reply_words[0].status));
               check_field("echo_command", int'(rsp_data.echo_command),
                           int'(reply_words[0].echo_command));
               check_field("reply_byte", int'(rsp_data.reply_byte),
                           int'(reply_words[0].reply_byte));
               check_field("reply_valid", int'(rsp_data.reply_valid),
                           int'(reply_words[0].reply_valid));
               check_field("last_result", int'(rsp_data.last_result),
                           int'(reply_words[0].last_result));
               void'(reply_words.pop_front());
            end
            words_taken++;
         end
         pop <= (words_taken >= 40 && words_taken < 140) || $urandom_range(99) >= 7;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      clear_frame();
      add_frame(KIND_GOOD, MIN_FRAME, 1'b0);
      add_word(8'hFF, 1'b0, 1'b0, 1'b0);
      add_word(8'h00, 1'b1, 1'b0, 1'b0);
      add_word(8'hFF, 1'b1, 1'b1, 1'b0);
      add_word(HEAD_0, 1'b0, 1'b0, 1'b0);
      add_word(HEAD_1, 1'b0, 1'b0, 1'b0);
      add_word(8'hA5, 1'b0, 1'b0, 1'b0);
      add_word(8'h00, 1'b0, 1'b1, 1'b0);
      add_word(8'h00, 1'b1, 1'b0, 1'b0);
      add_frame(KIND_BAD_SUM, MIN_FRAME, 1'b1);
      while (send_words.size() < WORD_TARGET) add_random_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (send_words.size() != 0 || push || reply_words.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== xor_frame_checker_with_error_reply.f =====
hw/rtl/xfc_pkg.sv
hw/rtl/xfc_front.sv
hw/rtl/xfc_queue.sv
hw/rtl/xfc_back.sv
hw/rtl/xor_frame_checker_with_error_reply.sv
hw/rtl/xfc_checker.sv
tb/xor_frame_checker_with_error_reply_tb.sv
